[design/rmd_pkg.sv]
// rmd_pkg: shared widths, constants and the sequencer state type for the
// rolling maximum drawdown block. No dependencies.
package rmd_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int RESULT_W  = 23;
   localparam int CFG_W     = 11;
   localparam int SCALE_W   = 23;
   localparam int PROD_W    = SAMPLE_W + SCALE_W;
   localparam int RATIO_W   = 2 * SAMPLE_W;
   localparam int DIV_STEPS = RESULT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // 100 percent with 16 fraction bits
   localparam logic [SCALE_W-1:0] SCALE_PERCENT_Q16 = 23'd6553600;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CUM_MUL,
      ST_CUM_CMP,
      ST_SCAN_RD,
      ST_SCAN_MUL,
      ST_SCAN_CMP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } rmd_state_type;

endpackage

[design/rmd_div.sv]
// rmd_div: forms floor((peak - value) * 100% Q16 / peak), one quotient bit per cycle.
// Depends on rmd_pkg. Steps: operand capture, one multiply, then DIV_STEPS shift-subtract steps.
module rmd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rmd_pkg::SAMPLE_W-1:0]  peak,
   input  logic [rmd_pkg::SAMPLE_W-1:0]  value,
   output logic                          done,
   output logic [rmd_pkg::RESULT_W-1:0]  quotient
);
   import rmd_pkg::*;

   logic [SAMPLE_W-1:0]  divisor_ff;
   logic [SAMPLE_W-1:0]  diff_ff;
   logic [SAMPLE_W-1:0]  rem_ff;
   logic [SAMPLE_W-1:0]  rem_in;
   logic [RESULT_W-1:0]  low_ff;
   logic [RESULT_W-1:0]  quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 mul_ff;
   logic                 done_ff;
   logic [PROD_W-1:0]    prod;
   logic [SAMPLE_W:0]    trial;
   logic [SAMPLE_W:0]    trial_sub;
   logic                 fits;

   assign prod      = PROD_W'(diff_ff) * PROD_W'(SCALE_PERCENT_Q16);
   assign trial     = {rem_ff, low_ff[RESULT_W-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign fits      = trial >= {1'b0, divisor_ff};
   // remainder stays below the divisor, so 32 bits always hold it
   assign rem_in    = fits ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            divisor_ff <= peak;
            diff_ff    <= peak - value;
            mul_ff     <= 1'b1;
         end else if (mul_ff) begin
            // quotient fits RESULT_W bits, so the upper product bits are below the divisor
            rem_ff <= prod[PROD_W-1 -: SAMPLE_W];
            low_ff <= prod[RESULT_W-1:0];
            cnt_ff <= DIV_CNT_W'(DIV_STEPS);
            mul_ff <= 1'b0;
         end else if (cnt_ff != '0) begin
            rem_ff  <= rem_in;
            low_ff  <= {low_ff[RESULT_W-2:0], 1'b0};
            quo_ff  <= {quo_ff[RESULT_W-2:0], fits};
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == DIV_CNT_W'(1));
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/rolling_max_drawdown.sv]
// Rolling maximum drawdown: for each accepted sample, the largest drop from a running peak
// over the last window_length samples (0: since series start, 1: zero), percent in Q16,
// floored. A zero sample takes a ring slot, returns the previous result with updated low.
// Items are taken one at a time, from idle only. A zero sample goes straight to the result;
// every other sample passes the cumulative compare, then a unit window ends, cumulative
// mode goes to the divider and a window scan covers N stored samples, at most WINDOW_MAX.
// The scan reads the sample ring through its single read port and compares each drop
// ratio with two registered multipliers, then one bit-serial divider forms the percentage.
// A new item can be taken while the previous result waits on the rsp side.
// Depends on rmd_pkg and rmd_div.
module rolling_max_drawdown #(
   parameter int WINDOW_MAX = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rmd_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          req_series_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rmd_pkg::RESULT_W-1:0]  rsp_drawdown_percent,
   output logic                          rsp_updated,
   input  logic                          csr_write_enable,
   input  logic [rmd_pkg::CFG_W-1:0]     csr_write_data
);
   import rmd_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int LW = (CW > CFG_W) ? CW : CFG_W;
   localparam int DW = CW + 1;

   // sample ring, undefined until written
   logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
   logic [SAMPLE_W-1:0] mem_q_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic                mem_re;

   rmd_state_type       state_ff, state_in;
   logic [CFG_W-1:0]    window_length_ff, window_length_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [SAMPLE_W-1:0] cum_peak_ff, cum_peak_in;
   logic [SAMPLE_W-1:0] cum_bv_ff, cum_bv_in;
   logic [SAMPLE_W-1:0] cum_bp_ff, cum_bp_in;
   logic [RESULT_W-1:0] last_ff, last_in;
   logic [SAMPLE_W-1:0] cand_v_ff, cand_v_in;
   logic [SAMPLE_W-1:0] cand_p_ff, cand_p_in;
   logic                cand_ok_ff, cand_ok_in;
   logic [SAMPLE_W-1:0] best_bv_ff, best_bv_in;
   logic [SAMPLE_W-1:0] best_bp_ff, best_bp_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [RATIO_W-1:0]  prod_a_ff, prod_a_in;
   logic [RATIO_W-1:0]  prod_b_ff, prod_b_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic [CW-1:0]       remain_ff, remain_in;
   logic                more_ff, more_in;
   logic [RESULT_W-1:0] res_ff, res_in;
   logic                upd_ff, upd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_dd_ff, rsp_dd_in;
   logic                rsp_upd_ff, rsp_upd_in;

   logic                accept;
   logic [AW-1:0]       wp_base, wp_next, rd_idx_inc;
   logic [CW-1:0]       fill_base, fill_next;
   logic [SAMPLE_W-1:0] cum_peak_base, cum_bv_base, cum_bp_base, cum_peak_new;
   logic [RESULT_W-1:0] last_base;
   logic [LW-1:0]       wl_ext;
   logic [CW-1:0]       win_n, scan_count;
   logic [DW-1:0]       start_sum;
   logic [AW-1:0]       start_idx;
   logic [SAMPLE_W-1:0] peak_new, mul_v, mul_p;
   logic                lt;
   logic                div_start, div_done;
   logic [RESULT_W-1:0] div_quotient;

   rmd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .peak     (best_bp_ff),
      .value    (best_bv_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= req_sample;
      end
      if (mem_re) begin
         mem_q_ff <= ring_mem[rd_idx_ff];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // series start clears history before this sample lands
   assign wp_base       = req_series_start ? '0 : wp_ff;
   assign fill_base     = req_series_start ? '0 : fill_ff;
   assign cum_peak_base = req_series_start ? '0 : cum_peak_ff;
   assign cum_bv_base   = req_series_start ? SAMPLE_W'(1) : cum_bv_ff;
   assign cum_bp_base   = req_series_start ? SAMPLE_W'(1) : cum_bp_ff;
   assign last_base     = req_series_start ? '0 : last_ff;
   assign wp_next       = (wp_base == AW'(WINDOW_MAX - 1)) ? '0 : wp_base + 1'b1;
   assign fill_next     = (fill_base < CW'(WINDOW_MAX)) ? fill_base + 1'b1 : fill_base;
   assign cum_peak_new  = (req_sample > cum_peak_base) ? req_sample : cum_peak_base;

   assign wl_ext     = LW'(window_length_ff);
   assign win_n      = (wl_ext > LW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(wl_ext);
   assign scan_count = (fill_ff < win_n) ? fill_ff : win_n;
   // oldest sample of the window, modulo the ring depth
   assign start_sum  = DW'(wp_ff) + DW'(WINDOW_MAX) - DW'(scan_count);
   assign start_idx  = (start_sum >= DW'(WINDOW_MAX)) ? AW'(start_sum - DW'(WINDOW_MAX))
                                                        : AW'(start_sum);
   assign rd_idx_inc = (rd_idx_ff == AW'(WINDOW_MAX - 1)) ? '0 : rd_idx_ff + 1'b1;

   assign peak_new = (mem_q_ff > peak_ff) ? mem_q_ff : peak_ff;
   assign mul_v    = (state_ff == ST_SCAN_MUL) ? mem_q_ff : cand_v_ff;
   assign mul_p    = (state_ff == ST_SCAN_MUL) ? peak_new : cand_p_ff;
   // a deeper drop means a smaller value/peak ratio: v*bp < bv*p
   assign prod_a_in = RATIO_W'(mul_v) * RATIO_W'(best_bp_ff);
   assign prod_b_in = RATIO_W'(best_bv_ff) * RATIO_W'(mul_p);
   assign lt        = prod_a_ff < prod_b_ff;

   assign window_length_in = csr_write_enable ? csr_write_data : window_length_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      cum_peak_in  = cum_peak_ff;
      cum_bv_in    = cum_bv_ff;
      cum_bp_in    = cum_bp_ff;
      last_in      = last_ff;
      cand_v_in    = cand_v_ff;
      cand_p_in    = cand_p_ff;
      cand_ok_in   = cand_ok_ff;
      best_bv_in   = best_bv_ff;
      best_bp_in   = best_bp_ff;
      peak_in      = peak_ff;
      rd_idx_in    = rd_idx_ff;
      remain_in    = remain_ff;
      more_in      = more_ff;
      res_in       = res_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dd_in    = rsp_dd_ff;
      rsp_upd_in   = rsp_upd_ff;
      mem_we       = 1'b0;
      mem_waddr    = wp_base;
      mem_re       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mem_we      = 1'b1;
               wp_in       = wp_next;
               fill_in     = fill_next;
               cum_bv_in   = cum_bv_base;
               cum_bp_in   = cum_bp_base;
               last_in     = last_base;
               if (req_sample == '0) begin
                  cum_peak_in = cum_peak_base;
                  res_in      = last_base;
                  upd_in      = 1'b0;
                  state_in    = ST_DONE;
               end else begin
                  cum_peak_in = cum_peak_new;
                  cand_v_in   = req_sample;
                  cand_p_in   = cum_peak_new;
                  best_bv_in  = cum_bv_base;
                  best_bp_in  = cum_bp_base;
                  state_in    = ST_CUM_MUL;
               end
            end
         end
         ST_CUM_MUL: begin
            state_in = ST_CUM_CMP;
         end
         ST_CUM_CMP: begin
            if (lt) begin
               cum_bv_in = cand_v_ff;
               cum_bp_in = cand_p_ff;
            end
            if (win_n == '0) begin
               best_bv_in = lt ? cand_v_ff : best_bv_ff;
               best_bp_in = lt ? cand_p_ff : best_bp_ff;
               state_in   = ST_DIV_GO;
            end else if (win_n == CW'(1)) begin
               res_in   = '0;
               upd_in   = 1'b1;
               last_in  = '0;
               state_in = ST_DONE;
            end else begin
               best_bv_in = SAMPLE_W'(1);
               best_bp_in = SAMPLE_W'(1);
               peak_in    = '0;
               rd_idx_in  = start_idx;
               remain_in  = scan_count;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            mem_re    = 1'b1;
            rd_idx_in = rd_idx_inc;
            remain_in = remain_ff - 1'b1;
            state_in  = ST_SCAN_MUL;
         end
         ST_SCAN_MUL: begin
            // zero entries are skipped: no peak update, no candidate
            cand_v_in  = mem_q_ff;
            cand_p_in  = peak_new;
            cand_ok_in = (mem_q_ff != '0);
            peak_in    = peak_new;
            more_in    = (remain_ff != '0);
            if (remain_ff != '0) begin
               mem_re    = 1'b1;
               rd_idx_in = rd_idx_inc;
               remain_in = remain_ff - 1'b1;
            end
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (cand_ok_ff && lt) begin
               best_bv_in = cand_v_ff;
               best_bp_in = cand_p_ff;
            end
            state_in = more_ff ? ST_SCAN_MUL : ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_in   = div_quotient;
               upd_in   = 1'b1;
               last_in  = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dd_in    = res_ff;
               rsp_upd_in   = upd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_length_ff <= '0;
         wp_ff            <= '0;
         fill_ff          <= '0;
         cum_peak_ff      <= '0;
         cum_bv_ff        <= SAMPLE_W'(1);
         cum_bp_ff        <= SAMPLE_W'(1);
         last_ff          <= '0;
         more_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         window_length_ff <= window_length_in;
         wp_ff            <= wp_in;
         fill_ff          <= fill_in;
         cum_peak_ff      <= cum_peak_in;
         cum_bv_ff        <= cum_bv_in;
         cum_bp_ff        <= cum_bp_in;
         last_ff          <= last_in;
         more_ff          <= more_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_v_ff  <= cand_v_in;
      cand_p_ff  <= cand_p_in;
      cand_ok_ff <= cand_ok_in;
      best_bv_ff <= best_bv_in;
      best_bp_ff <= best_bp_in;
      peak_ff    <= peak_in;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      rd_idx_ff  <= rd_idx_in;
      remain_ff  <= remain_in;
      res_ff     <= res_in;
      upd_ff     <= upd_in;
      rsp_dd_ff  <= rsp_dd_in;
      rsp_upd_ff <= rsp_upd_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drawdown_percent = rsp_dd_ff;
   assign rsp_updated          = rsp_upd_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drawdown_percent <= RESULT_W'(SCALE_PERCENT_Q16))
      else $error("drawdown above 100 percent");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(WINDOW_MAX))
      else $error("fill count beyond ring depth");

   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_GO |-> best_bp_ff != '0 && best_bv_ff <= best_bp_ff)
      else $error("bad divider operands");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_CMP && !more_ff |=> state_ff == ST_DIV_GO)
      else $error("scan did not hand over to the divider");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for rolling_max_drawdown, with a built-in drawdown
// predictor, random valid/ready idling and a long response hold-off.
// Depends on rmd_pkg and the rolling_max_drawdown RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD     = 8;
   localparam int          RESET_CYCLES   = 9;
   localparam int          WINDOW_MAX     = 1024;
   localparam int          RX_HOLD_CYCLES = 600;
   localparam int          END_SETTLE     = 2 * WINDOW_MAX + 64;
   localparam int unsigned CYCLE_LIMIT    = 10_000_000;

   typedef logic [rmd_pkg::SAMPLE_W-1:0] sample_type;
   typedef logic [rmd_pkg::RESULT_W-1:0] pct_type;
   typedef logic [rmd_pkg::CFG_W-1:0]    wlen_type;

   typedef struct packed {
      pct_type pct;
      logic    updated;
   } drawdown_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   sample_type req_sample;
   logic       req_series_start;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   pct_type    rsp_drawdown_percent;
   logic       rsp_updated;
   logic       csr_write_enable;
   wlen_type   csr_write_data;

   // predictor state
   sample_type  ring_model [WINDOW_MAX];
   int unsigned wr_ptr = 0;
   int unsigned filled = 0;
   sample_type  cum_peak = '0;
   pct_type     cum_worst = '0;
   pct_type     held_pct = '0;
   wlen_type    window_len = '0;

   drawdown_type expected_drawdowns[$];

   sample_type  walk_price = 32'd1_000_000;
   bit          tx_idling = 1'b1;
   bit          rx_idling = 1'b1;
   int unsigned rx_hold_requests = 0;
   int unsigned rx_hold_served = 0;
   int unsigned rx_hold_left = 0;
   int unsigned rx_stall_left = 0;

   int unsigned n_samples = 0;
   int unsigned n_invalid = 0;
   int unsigned n_starts = 0;
   int unsigned n_settings = 0;
   int unsigned n_checked = 0;
   int unsigned n_errors = 0;
   int unsigned cycle_count = 0;

   rolling_max_drawdown #(
      .WINDOW_MAX (WINDOW_MAX)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample           (req_sample),
      .req_series_start     (req_series_start),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_drawdown_percent (rsp_drawdown_percent),
      .rsp_updated          (rsp_updated),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_drawdowns.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic pct_type drop_pct(input sample_type peak, input sample_type v);
      logic [63:0] num;
      if (peak == '0 || v >= peak)
         return '0;
      num = 64'(peak - v) * 64'(rmd_pkg::SCALE_PERCENT_Q16);
      return pct_type'(num / 64'(peak));
   endfunction

   // oldest to newest over the last count slots, peak restarting at the oldest
   function automatic pct_type window_worst(input int unsigned count);
      int unsigned idx;
      sample_type  peak;
      pct_type     worst;
      pct_type     d;
      idx   = (wr_ptr + WINDOW_MAX - count) % WINDOW_MAX;
      peak  = '0;
      worst = '0;
      for (int unsigned k = 0; k < count; k++) begin
         if (ring_model[idx] != '0) begin
            if (ring_model[idx] > peak)
               peak = ring_model[idx];
            d = drop_pct(peak, ring_model[idx]);
            if (d > worst)
               worst = d;
         end
         idx = (idx + 1) % WINDOW_MAX;
      end
      return worst;
   endfunction

   function automatic drawdown_type predict_drawdown(input sample_type s, input logic start);
      drawdown_type r;
      int unsigned  n;
      int unsigned  count;
      pct_type      d;
      if (start) begin
         wr_ptr    = 0;
         filled    = 0;
         cum_peak  = '0;
         cum_worst = '0;
         held_pct  = '0;
      end
      ring_model[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
      if (filled < WINDOW_MAX)
         filled++;
      // invalid point: slot taken, everything else untouched
      if (s == '0) begin
         r.pct     = held_pct;
         r.updated = 1'b0;
         return r;
      end
      if (s > cum_peak)
         cum_peak = s;
      d = drop_pct(cum_peak, s);
      if (d > cum_worst)
         cum_worst = d;
      n = (window_len > WINDOW_MAX) ? WINDOW_MAX : 32'(window_len);
      if (n == 0)
         held_pct = cum_worst;
      else if (n == 1)
         held_pct = '0;
      else begin
         count    = (filled < n) ? filled : n;
         held_pct = window_worst(count);
      end
      r.pct     = held_pct;
      r.updated = 1'b1;
      return r;
   endfunction

   // ---------------- response side ----------------

   always @(negedge clock) begin
      if (rx_hold_served != rx_hold_requests) begin
         rx_hold_served = rx_hold_requests;
         rx_hold_left   = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_ready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
         rx_stall_left = $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      n_errors++;
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : rsp_check
      drawdown_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drawdowns.size() == 0) begin
            report_mismatch("transfer with nothing pending", 32'd0,
                            32'(rsp_drawdown_percent));
         end else begin
            want = expected_drawdowns.pop_front();
            n_checked++;
            if (rsp_drawdown_percent !== want.pct)
               report_mismatch("drawdown_percent", 32'(want.pct),
                               32'(rsp_drawdown_percent));
            if (rsp_updated !== want.updated)
               report_mismatch("updated", 32'(want.updated), 32'(rsp_updated));
         end
      end
   end

   // ---------------- request side ----------------

   task automatic send_sample(input sample_type s, input logic start);
      int gap;
      gap = (tx_idling && $urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_sample       <= s;
      req_series_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_drawdowns.push_back(predict_drawdown(s, start));
      n_samples++;
      if (s == '0)
         n_invalid++;
      if (start)
         n_starts++;
   endtask

   // mostly a random walk with steps of 1/64 to 1/2 of the price, plus invalid points,
   // full-range values and the extremes
   function automatic sample_type next_price();
      int unsigned r;
      sample_type  step;
      r = $urandom_range(0, 99);
      if (r < 5)
         return '0;
      if (r < 9) begin
         walk_price = $urandom();
         if (walk_price == '0)
            walk_price = 32'd1;
         return walk_price;
      end
      if (r < 11) begin
         walk_price = '1;
         return walk_price;
      end
      if (r < 13) begin
         walk_price = 32'd1;
         return walk_price;
      end
      step = walk_price >> $urandom_range(1, 6);
      if (step == '0)
         step = $urandom_range(1, 1000);
      if (r < 56)
         walk_price = (walk_price > step) ? walk_price - step : 32'd1;
      else
         walk_price = (walk_price > ~step) ? '1 : walk_price + step;
      return walk_price;
   endfunction

   task automatic send_walk(input int count, input int start_pct);
      logic start;
      for (int i = 0; i < count; i++) begin
         start = ($urandom_range(0, 99) < start_pct);
         send_sample(next_price(), start);
      end
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drawdowns.size() != 0) @(posedge clock);
   endtask

   task automatic set_window(input wlen_type len);
      wait_all_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      window_len = len;
      n_settings++;
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      // cumulative mode straight out of reset
      send_sample(32'd100, 1'b1);
      send_sample(32'd50, 1'b0);
      send_sample(32'd0, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'd1, 1'b0);
      // series start on an invalid point clears the held value
      send_sample(32'd0, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFE, 1'b0);
      // unit window
      set_window(11'd1);
      send_sample(32'd200, 1'b0);
      send_sample(32'd100, 1'b0);
      // an invalid point still occupies its window slot
      set_window(11'd2);
      send_sample(32'd1000, 1'b1);
      send_sample(32'd500, 1'b0);
      send_sample(32'd0, 1'b0);
      send_sample(32'd250, 1'b0);
      send_sample(32'd125, 1'b0);
      // window longer than the history so far
      set_window(11'd5);
      send_sample(32'd400, 1'b1);
      send_sample(32'd300, 1'b0);
      send_sample(32'd100, 1'b0);
      // oversized length saturates
      set_window(11'h7FF);
      send_sample(32'd7, 1'b1);
      send_sample(32'd3, 1'b0);
      send_sample(32'd0, 1'b0);
      send_sample(32'd2, 1'b0);
   endtask

   task automatic test_random_windows();
      wlen_type len;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: len = wlen_type'($urandom_range(3, 64));
            1: len = 11'd2;
            2: len = 11'd0;
            3: len = 11'd1;
            4: len = wlen_type'($urandom_range(3, 16));
            5: len = wlen_type'($urandom_range(100, 300));
            6: len = 11'd3;
            default: len = wlen_type'($urandom_range(17, 64));
         endcase
         tx_idling = ($urandom_range(0, 3) != 0);
         rx_idling = ($urandom_range(0, 3) != 0);
         set_window(len);
         // no restarts before the cumulative phase so it sees earlier history
         send_walk(45, (ph == 1) ? 0 : 3);
      end
   endtask

   task automatic test_backpressure();
      tx_idling = 1'b0;
      rx_idling = 1'b1;
      set_window(11'd8);
      rx_hold_requests++;
      send_walk(30, 0);
      wait_all_results();
      tx_idling = 1'b1;
      send_walk(20, 5);
   endtask

   // long and oversized windows over one unbroken series
   task automatic test_long_windows();
      tx_idling = 1'b1;
      rx_idling = 1'b1;
      set_window(11'd1);
      send_sample(next_price(), 1'b1);
      send_walk(50, 0);
      set_window(11'd1024);
      send_walk(4, 0);
      set_window(11'h7FF);
      send_walk(4, 0);
      set_window(11'd1000);
      send_walk(4, 0);
      set_window(11'd0);
      send_walk(4, 0);
   endtask

   task automatic test_final_burst();
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      set_window(wlen_type'($urandom_range(2, 32)));
      send_walk(60, 3);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      req_series_start = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      foreach (ring_model[i])
         ring_model[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_windows();
      test_backpressure();
      test_long_windows();
      test_final_burst();

      wait_all_results();
      repeat (END_SETTLE) @(posedge clock);

      $display("run covered %0d samples (%0d invalid, %0d series starts) over %0d window settings",
               n_samples, n_invalid, n_starts, n_settings);
      $display("including long windows and a long response hold-off; %0d results checked",
               n_checked);
      if (n_errors == 0 && expected_drawdowns.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
design/rmd_pkg.sv
design/rmd_div.sv
design/rolling_max_drawdown.sv
tb/tb_top.sv
